// ----- src/h2d_pkg.sv -----
// ----------------------------------------------------------------------------
// h2d_pkg
// shared types, constants and arithmetic for the multilevel 2-d haar transform
// ----------------------------------------------------------------------------
package h2d_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_MAX_LEVELS = 4;

   // hard cap on cells, set by the two-bit level field
   localparam int STAGES      = 4;
   localparam int SLOT_W      = $clog2(STAGES);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [10:0] RESET_WIDTH  = 11'd1024;
   localparam logic [10:0] RESET_HEIGHT = 11'd1024;
   localparam logic [2:0]  RESET_LEVELS = 3'd1;

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_LEVEL_COUNT  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic       made;
      logic [8:0] row;
      logic [8:0] col;
      logic [7:0] ap;
      logic [7:0] hd;
      logic [7:0] vd;
      logic [7:0] dd;
   } result_type;

   typedef struct packed {
      logic                    valid;
      logic                    carry;
      logic [7:0]              sample;
      result_type [STAGES-1:0] slot;
   } group_type;

   typedef struct packed {
      logic en;
      logic clear;
      logic active;
   } cell_ctrl_type;

   // truncate toward zero after dividing by four, then keep one byte
   function automatic logic [7:0] quarter(input logic signed [10:0] s);
      logic signed [10:0] t;
      t = s + (s[10] ? 11'sd3 : 11'sd0);
      return 8'(t >>> 2);
   endfunction

endpackage

// ----- src/haar_2d_multilevel_forward.sv -----
// ----------------------------------------------------------------------------
// haar_2d_multilevel_forward
// streaming forward 2-d haar transform over up to four levels
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | word
//  req     | in        | valid / stall    | pixel
//  rsp     | out       | valid / stall    | level, row, col, four coefficients, last
//  csr     | in        | valid / ready    | index, data
//
//  one pixel per cycle while req_stall is low; each word walks the row of level cells;
//  one that closes a level-0 block enters the group queue, then the output register;
//  results leave one per cycle while rsp_stall is low; a pixel that closes blocks on
//  k levels yields k words; req_stall rises while the four-entry group queue is full
//  reset clears counters and queues; line stores need no clearing pass
// ----------------------------------------------------------------------------
module haar_2d_multilevel_forward #(
   parameter int MAX_WIDTH  = h2d_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = h2d_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_LEVELS = h2d_pkg::DEF_MAX_LEVELS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_level,
   output logic [8:0]  rsp_coef_row,
   output logic [8:0]  rsp_coef_col,
   output logic [7:0]  rsp_approximation,
   output logic [7:0]  rsp_horizontal_detail,
   output logic [7:0]  rsp_vertical_detail,
   output logic [7:0]  rsp_diagonal_detail,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);

   localparam int NUM_CELLS = (MAX_LEVELS < h2d_pkg::STAGES) ? MAX_LEVELS : h2d_pkg::STAGES;
   localparam int CW        = $clog2(MAX_WIDTH + 1);
   localparam int RW        = $clog2(MAX_HEIGHT + 1);
   localparam int WCMP      = (CW > 11) ? CW : 11;
   localparam int HCMP      = (RW > 11) ? RW : 11;

   logic [10:0] image_width_ff, image_height_ff;
   logic [2:0]  level_count_ff;
   logic        csr_write, clear, en, full;

   logic [WCMP-1:0] wext;
   logic [HCMP-1:0] hext;
   logic [CW-1:0]   w0;
   logic [RW-1:0]   h0;
   logic [2:0]      levels;

   h2d_pkg::group_type tok [0:NUM_CELLS];

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_comb begin
      clear = 1'b0;
      unique case (h2d_pkg::csr_index_type'(csr_index))
         h2d_pkg::CSR_IMAGE_WIDTH,
         h2d_pkg::CSR_IMAGE_HEIGHT,
         h2d_pkg::CSR_LEVEL_COUNT: clear = csr_write;
         default:                  clear = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= h2d_pkg::RESET_WIDTH;
         image_height_ff <= h2d_pkg::RESET_HEIGHT;
         level_count_ff  <= h2d_pkg::RESET_LEVELS;
      end else if (csr_write) begin
         unique case (h2d_pkg::csr_index_type'(csr_index))
            h2d_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_data;
            h2d_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_data;
            h2d_pkg::CSR_LEVEL_COUNT:  level_count_ff  <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // clamp geometry and level count to the supported range
   assign wext = WCMP'(image_width_ff);
   assign hext = HCMP'(image_height_ff);

   always_comb begin
      if (wext < WCMP'(2)) begin
         w0 = CW'(2);
      end else if (wext > WCMP'(MAX_WIDTH)) begin
         w0 = CW'(MAX_WIDTH);
      end else begin
         w0 = CW'(wext);
      end
      if (hext < HCMP'(2)) begin
         h0 = RW'(2);
      end else if (hext > HCMP'(MAX_HEIGHT)) begin
         h0 = RW'(MAX_HEIGHT);
      end else begin
         h0 = RW'(hext);
      end
      if (level_count_ff == 3'd0) begin
         levels = 3'd1;
      end else if (level_count_ff > 3'(NUM_CELLS)) begin
         levels = 3'(NUM_CELLS);
      end else begin
         levels = level_count_ff;
      end
   end

   assign en        = ~full;
   assign req_stall = full;

   always_comb begin
      tok[0]        = '0;
      tok[0].valid  = req_valid;
      tok[0].carry  = 1'b1;
      tok[0].sample = req_pixel;
   end

   for (genvar l = 0; l < NUM_CELLS; l++) begin : g_cell
      logic [CW-1:0]          wl_sh, wl;
      logic [RW-1:0]          hl_sh, hl;
      h2d_pkg::cell_ctrl_type ctrl;

      assign wl_sh = w0 >> l;
      assign hl_sh = h0 >> l;
      assign wl    = (wl_sh == '0) ? CW'(1) : wl_sh;
      assign hl    = (hl_sh == '0) ? RW'(1) : hl_sh;

      assign ctrl.en     = en;
      assign ctrl.clear  = clear;
      assign ctrl.active = (3'(l) < levels);

      h2d_cell #(
         .LEVEL     (l),
         .MAX_WIDTH (MAX_WIDTH),
         .CW        (CW),
         .RW        (RW)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .width   (wl),
         .height  (hl),
         .tok_in  (tok[l]),
         .tok_out (tok[l+1])
      );
   end

   h2d_out_queue u_out (
      .clock                 (clock),
      .reset                 (reset),
      .en                    (en),
      .grp                   (tok[NUM_CELLS]),
      .full                  (full),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_level             (rsp_level),
      .rsp_coef_row          (rsp_coef_row),
      .rsp_coef_col          (rsp_coef_col),
      .rsp_approximation     (rsp_approximation),
      .rsp_horizontal_detail (rsp_horizontal_detail),
      .rsp_vertical_detail   (rsp_vertical_detail),
      .rsp_diagonal_detail   (rsp_diagonal_detail),
      .rsp_last              (rsp_last)
   );

endmodule

// ----- src/h2d_cell.sv -----
// ----------------------------------------------------------------------------
// h2d_cell
// one decomposition level: line store, counters, 2x2 block arithmetic
// ----------------------------------------------------------------------------
module h2d_cell #(
   parameter int LEVEL     = 0,
   parameter int MAX_WIDTH = h2d_pkg::DEF_MAX_WIDTH,
   parameter int CW        = 11,
   parameter int RW        = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  h2d_pkg::cell_ctrl_type ctrl,
   input  logic [CW-1:0]          width,
   input  logic [RW-1:0]          height,
   input  h2d_pkg::group_type     tok_in,
   output h2d_pkg::group_type     tok_out
);

   localparam int RAW_DEPTH = MAX_WIDTH >> (LEVEL + 1);
   localparam int MIN_DEPTH = (RAW_DEPTH < 2) ? 2 : RAW_DEPTH;
   localparam int AW        = $clog2(MIN_DEPTH);
   localparam int DEPTH     = 2 ** AW;

   logic [15:0]         line_mem [0:DEPTH-1];
   logic [15:0]         rdata_ff;
   logic [7:0]          held_ff;
   logic [CW-1:0]       col_ff, col_in;
   logic [RW-1:0]       row_ff, row_in;
   h2d_pkg::group_type  tok_ff, tok_in_c;

   logic                take, proc, upper, odd, made;
   logic [AW-1:0]       addr;
   logic [7:0]          a, b, c, d;
   logic signed [10:0]  sa, sb, sc, sd;
   logic [CW-1:0]       col_half;
   logic [RW-1:0]       row_half;
   h2d_pkg::result_type res;

   assign take  = tok_in.valid & tok_in.carry & ctrl.active;
   assign proc  = ctrl.en & take;
   assign upper = ~row_ff[0];
   assign odd   = col_ff[0];
   assign made  = take & ~upper & odd;
   assign addr  = col_ff[AW:1];

   assign a  = rdata_ff[15:8];
   assign b  = rdata_ff[7:0];
   assign c  = held_ff;
   assign d  = tok_in.sample;
   assign sa = $signed({3'b000, a});
   assign sb = $signed({3'b000, b});
   assign sc = $signed({3'b000, c});
   assign sd = $signed({3'b000, d});

   assign col_half = col_ff >> 1;
   assign row_half = row_ff >> 1;

   always_comb begin
      res.made = made;
      res.row  = 9'(row_half);
      res.col  = 9'(col_half);
      res.ap   = h2d_pkg::quarter(sa + sb + sc + sd);
      res.hd   = h2d_pkg::quarter(sa + sb - sc - sd);
      res.vd   = h2d_pkg::quarter(sa - sb + sc - sd);
      res.dd   = h2d_pkg::quarter(sa - sb - sc + sd);
   end

   always_comb begin
      tok_in_c             = tok_in;
      tok_in_c.carry       = made;
      tok_in_c.sample      = res.ap;
      tok_in_c.slot[LEVEL] = made ? res : '0;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (ctrl.clear) begin
         col_in = '0;
         row_in = '0;
      end else if (proc) begin
         if (col_ff + CW'(1) >= width) begin
            col_in = '0;
            row_in = (row_ff + RW'(1) >= height) ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         held_ff <= '0;
         tok_ff  <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (proc && !odd) begin
            held_ff <= d;
         end
         if (ctrl.en) begin
            tok_ff <= tok_in_c;
         end
      end
   end

   // upper rows store pairs; the lower row fetches its pair at the even column
   always_ff @(posedge clock) begin
      if (proc && upper && odd) begin
         line_mem[addr] <= {held_ff, d};
      end
      if (proc && !upper && !odd) begin
         rdata_ff <= line_mem[addr];
      end
   end

   assign tok_out = tok_ff;

endmodule

// ----- src/h2d_out_queue.sv -----
// ----------------------------------------------------------------------------
// h2d_out_queue
// queue of result groups and serializer onto the result channel
// ----------------------------------------------------------------------------
module h2d_out_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  h2d_pkg::group_type grp,
   output logic               full,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_level,
   output logic [8:0]         rsp_coef_row,
   output logic [8:0]         rsp_coef_col,
   output logic [7:0]         rsp_approximation,
   output logic [7:0]         rsp_horizontal_detail,
   output logic [7:0]         rsp_vertical_detail,
   output logic [7:0]         rsp_diagonal_detail,
   output logic               rsp_last
);

   h2d_pkg::group_type             q_ff [0:h2d_pkg::QUEUE_DEPTH-1];
   logic [h2d_pkg::QPTR_W-1:0]     wr_ff, rd_ff;
   logic [h2d_pkg::QPTR_W:0]       count_ff, count_in;
   logic [h2d_pkg::SLOT_W-1:0]     sel_ff, sel_in;
   logic                           valid_ff, valid_in;
   h2d_pkg::result_type            out_ff;
   logic [1:0]                     level_ff;
   logic                           last_ff;

   h2d_pkg::group_type             head;
   h2d_pkg::result_type            cur;
   logic [h2d_pkg::STAGES-1:0]     more;
   logic                           push, pop, load, last;

   assign full = (count_ff == (h2d_pkg::QPTR_W + 1)'(h2d_pkg::QUEUE_DEPTH));
   assign push = en & grp.valid & grp.slot[0].made;
   assign head = q_ff[rd_ff];
   assign cur  = head.slot[sel_ff];
   assign load = (count_ff != '0) & (~valid_ff | ~rsp_stall);

   always_comb begin
      for (int i = 0; i < h2d_pkg::STAGES; i++) begin
         more[i] = (i < h2d_pkg::STAGES - 1) ? head.slot[(i + 1) % h2d_pkg::STAGES].made
                                             : 1'b0;
      end
   end

   assign last     = ~more[sel_ff];
   assign pop      = load & last;
   assign count_in = count_ff + (h2d_pkg::QPTR_W + 1)'(push) - (h2d_pkg::QPTR_W + 1)'(pop);
   assign sel_in   = load ? (last ? '0 : sel_ff + h2d_pkg::SLOT_W'(1)) : sel_ff;
   assign valid_in = load ? 1'b1 : (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
         sel_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
         if (push) begin
            wr_ff <= wr_ff + h2d_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + h2d_pkg::QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= grp;
      end
      if (load) begin
         out_ff   <= cur;
         level_ff <= 2'(sel_ff);
         last_ff  <= last;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_level             = level_ff;
   assign rsp_coef_row          = out_ff.row;
   assign rsp_coef_col          = out_ff.col;
   assign rsp_approximation     = out_ff.ap;
   assign rsp_horizontal_detail = out_ff.hd;
   assign rsp_vertical_detail   = out_ff.vd;
   assign rsp_diagonal_detail   = out_ff.dd;
   assign rsp_last              = last_ff;

endmodule

// ----- src/h2d_checker.sv -----
// ----------------------------------------------------------------------------
// h2d_checker
// port-level checks on the result channel of the haar transform
// ----------------------------------------------------------------------------
module h2d_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_level,
   input logic [8:0]  rsp_coef_row,
   input logic [8:0]  rsp_coef_col,
   input logic [7:0]  rsp_approximation,
   input logic [7:0]  rsp_horizontal_detail,
   input logic [7:0]  rsp_vertical_detail,
   input logic [7:0]  rsp_diagonal_detail,
   input logic        rsp_last
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable({rsp_level, rsp_coef_row,
         rsp_coef_col, rsp_approximation, rsp_horizontal_detail, rsp_vertical_detail,
         rsp_diagonal_detail, rsp_last}))
      else $error("stalled result word changed");

   a_group_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         rsp_valid && rsp_level == $past(rsp_level) + 2'd1)
      else $error("group does not continue with the next level");

   a_group_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last |=> !rsp_valid || rsp_level == 2'd0)
      else $error("group does not start at level zero");

   a_top_level_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_level == 2'd3 |-> rsp_last)
      else $error("coarsest level word not marked last");

endmodule

bind haar_2d_multilevel_forward h2d_checker u_h2d_checker (.*);
